FILE: rtl/cba_pkg.sv
package cba_pkg;

  localparam int MAX_BLOCKS_DEF = 256;

  localparam int FUNC_W    = 2;
  localparam int SIZE_W    = 24;
  localparam int BB_W      = 17;
  localparam int BIU_W     = 9;
  localparam int HEAD_W    = 8;
  localparam int CFG_IDX_W = 1;
  localparam int WORD_BITS = 8;
  localparam int WORD_SH   = 3;
  localparam int EXT_W     = SIZE_W + 1;
  localparam int DIV_CW    = $clog2(SIZE_W);

  localparam logic [BB_W-1:0]  BB_RESET  = BB_W'(64);
  localparam logic [BB_W-1:0]  BB_MAX    = BB_W'(65536);
  localparam logic [BIU_W-1:0] BIU_RESET = BIU_W'(256);

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ALLOC = 2'd0,
    FUNC_FREE  = 2'd1,
    FUNC_CLEAR = 2'd2
  } func_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BLOCK_BYTES   = 1'b0,
    CFG_BLOCKS_IN_USE = 1'b1
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_DIV1,
    ST_DIV2,
    ST_SCAN_RD,
    ST_SCAN_EV,
    ST_MARK_RD,
    ST_MARK_WR,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [SIZE_W-1:0] size_bytes;
    logic [SIZE_W-1:0] offset_in;
  } in_beat_t;

  typedef struct packed {
    logic              ok;
    logic [HEAD_W-1:0] head_block;
    logic [SIZE_W-1:0] offset_out;
  } out_beat_t;

  typedef struct packed {
    logic              done;
    logic [SIZE_W-1:0] quot;
    logic              rem_nz;
  } div_res_t;

endpackage

FILE: rtl/cba_ram.sv
module cba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/cba_div.sv
module cba_div (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [cba_pkg::SIZE_W-1:0] dividend_i,
  input  logic [cba_pkg::BB_W-1:0]   divisor_i,
  output cba_pkg::div_res_t      res_o
);

  import cba_pkg::*;

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [DIV_CW-1:0] cnt_q, cnt_d;
  logic [SIZE_W-1:0] quot_q, quot_d;
  logic [BB_W-1:0]   rem_q, rem_d;
  logic [BB_W:0]     rem_sh;
  logic              ge;

  // one quotient bit per cycle, restoring
  always_comb begin
    rem_sh = {rem_q, quot_q[SIZE_W-1]};
    ge     = rem_sh >= {1'b0, divisor_i};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quot_d = quot_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quot_d = dividend_i;
      rem_d  = '0;
    end else if (busy_q) begin
      quot_d = {quot_q[SIZE_W-2:0], ge};
      rem_d  = ge ? BB_W'(rem_sh - {1'b0, divisor_i}) : BB_W'(rem_sh);
      cnt_d  = cnt_q + DIV_CW'(1);
      if (cnt_q == DIV_CW'(SIZE_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
  end

  assign res_o.done   = done_q;
  assign res_o.quot   = quot_q;
  assign res_o.rem_nz = rem_q != '0;

endmodule

FILE: rtl/contiguous_block_allocator.sv
// channel   direction  handshake                 beat
// in        input      in_valid_i / in_stall_o   in_beat_i   (func, size_bytes, offset_in)
// out       output     out_valid_o / out_stall_i out_beat_o  (ok, head_block, offset_out)
// cfg       input      cfg_we_i                  cfg_idx_i, cfg_wdata_i
//
// one item at a time; the used marks live in a ram of 8-bit words.
// alloc: a divide, then a read and an evaluate per bitmap word scanned, a read and a write per word marked.
// free: two divides, then a read and a write per word touched. clear: one write per word.
// after reset a clearing pass over all ceil(MAX_BLOCKS/8) words runs before any beat is taken.
// the next beat is taken while a result beat is still stalled in the output register.
module contiguous_block_allocator #(
  parameter int MAX_BLOCKS = cba_pkg::MAX_BLOCKS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  cba_pkg::in_beat_t             in_beat_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output cba_pkg::out_beat_t            out_beat_o,
  input  logic                          cfg_we_i,
  input  logic [cba_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [cba_pkg::BB_W-1:0]      cfg_wdata_i
);

  import cba_pkg::*;

  localparam int DEPTH = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int IX_W  = AW + WORD_SH + 1;
  localparam int PW    = IX_W + BB_W;

  state_e state_q, state_d;

  logic [BB_W-1:0]   bb_cfg_q;
  logic [BIU_W-1:0]  biu_cfg_q;
  logic [BB_W-1:0]   bb;
  logic [IX_W-1:0]   lim;

  logic [AW-1:0]     word_q, word_d;
  logic [IX_W-1:0]   run_q, run_d;
  logic [IX_W-1:0]   start_q, start_d;
  logic [IX_W-1:0]   need_q, need_d;
  logic [IX_W-1:0]   lo_q, lo_d;
  logic [IX_W-1:0]   hi_q, hi_d;
  logic              set_q, set_d;
  logic              is_free_q, is_free_d;
  logic [SIZE_W-1:0] size_q, size_d;
  logic [SIZE_W-1:0] first_q, first_d;
  logic              res_ok_q, res_ok_d;
  logic              res_hit_q, res_hit_d;
  logic              pend_q, pend_d;
  logic              out_valid_q, out_valid_d;
  out_beat_t         out_beat_q, out_beat_d;

  logic              acc;
  logic              out_free;
  logic              div_start;
  logic [SIZE_W-1:0] div_dividend;
  div_res_t          div_res;

  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [WORD_BITS-1:0] ram_wdata, ram_rdata;

  logic [EXT_W-1:0]  blocks_ext;
  logic              need_bad;
  logic [EXT_W-1:0]  end_ext, hi_ext;
  logic              free_none;
  logic              found_c;
  logic [IX_W-1:0]   run_c, start_c;
  logic [IX_W-1:0]   next_base;
  logic              scan_last, mark_last, sweep_last;
  logic [WORD_BITS-1:0] mark_data;
  logic [PW-1:0]     prod;

  // effective configuration
  always_comb begin
    if (bb_cfg_q == '0) begin
      bb = BB_W'(1);
    end else if (bb_cfg_q > BB_MAX) begin
      bb = BB_MAX;
    end else begin
      bb = bb_cfg_q;
    end
    if (biu_cfg_q == '0) begin
      lim = IX_W'(1);
    end else if (EXT_W'(biu_cfg_q) > EXT_W'(MAX_BLOCKS)) begin
      lim = IX_W'(MAX_BLOCKS);
    end else begin
      lim = IX_W'(biu_cfg_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bb_cfg_q  <= BB_RESET;
      biu_cfg_q <= BIU_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_BLOCK_BYTES:   bb_cfg_q  <= cfg_wdata_i;
        CFG_BLOCKS_IN_USE: biu_cfg_q <= BIU_W'(cfg_wdata_i);
        default: ;
      endcase
    end
  end

  cba_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (DEPTH)
  ) u_marks (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  cba_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (bb),
    .res_o      (div_res)
  );

  assign acc      = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;

  // decisions shared by the next-state and datapath blocks
  always_comb begin
    blocks_ext = EXT_W'(div_res.quot) + EXT_W'(div_res.rem_nz);
    need_bad   = (blocks_ext == '0) || (blocks_ext > EXT_W'(lim));
    end_ext    = EXT_W'(first_q) + blocks_ext;
    hi_ext     = (end_ext < EXT_W'(lim)) ? end_ext : EXT_W'(lim);
    free_none  = (blocks_ext == '0) || (EXT_W'(first_q) >= hi_ext);
    next_base  = (IX_W'(word_q) + IX_W'(1)) << WORD_SH;
    scan_last  = next_base >= lim;
    mark_last  = next_base >= hi_q;
    sweep_last = word_q == AW'(DEPTH - 1);
  end

  // run search over one bitmap word
  always_comb begin
    logic [IX_W-1:0] idx;
    found_c = 1'b0;
    run_c   = run_q;
    start_c = start_q;
    for (int j = 0; j < WORD_BITS; j++) begin
      idx = IX_W'({word_q, WORD_SH'(j)});
      if (!found_c && idx < lim) begin
        if (!ram_rdata[j]) begin
          if (run_c == '0) begin
            start_c = idx;
          end
          run_c = run_c + IX_W'(1);
          if (run_c == need_q) begin
            found_c = 1'b1;
          end
        end else begin
          run_c = '0;
        end
      end
    end
  end

  always_comb begin
    logic [IX_W-1:0] idx;
    mark_data = ram_rdata;
    for (int j = 0; j < WORD_BITS; j++) begin
      idx = IX_W'({word_q, WORD_SH'(j)});
      if (idx >= lo_q && idx < hi_q) begin
        mark_data[j] = set_q;
      end
    end
  end

  assign prod = PW'(start_q) * PW'(bb);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_SWEEP: begin
        if (sweep_last) begin
          state_d = pend_q ? ST_DONE : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (acc) begin
          case (in_beat_i.func)
            FUNC_ALLOC, FUNC_FREE: state_d = ST_DIV1;
            FUNC_CLEAR:            state_d = ST_SWEEP;
            default:               state_d = ST_DONE;
          endcase
        end
      end
      ST_DIV1: begin
        if (div_res.done) begin
          if (is_free_q) begin
            state_d = ST_DIV2;
          end else begin
            state_d = need_bad ? ST_DONE : ST_SCAN_RD;
          end
        end
      end
      ST_DIV2: begin
        if (div_res.done) begin
          state_d = free_none ? ST_DONE : ST_MARK_RD;
        end
      end
      ST_SCAN_RD: state_d = ST_SCAN_EV;
      ST_SCAN_EV: begin
        if (found_c) begin
          state_d = ST_MARK_RD;
        end else if (scan_last) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_SCAN_RD;
        end
      end
      ST_MARK_RD: state_d = ST_MARK_WR;
      ST_MARK_WR: state_d = mark_last ? ST_DONE : ST_MARK_RD;
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and ram control
  always_comb begin
    word_d       = word_q;
    run_d        = run_q;
    start_d      = start_q;
    need_d       = need_q;
    lo_d         = lo_q;
    hi_d         = hi_q;
    set_d        = set_q;
    is_free_d    = is_free_q;
    size_d       = size_q;
    first_d      = first_q;
    res_ok_d     = res_ok_q;
    res_hit_d    = res_hit_q;
    pend_d       = pend_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_beat_d   = out_beat_q;
    div_start    = 1'b0;
    div_dividend = in_beat_i.size_bytes;
    ram_we       = 1'b0;
    ram_waddr    = word_q;
    ram_wdata    = '0;
    ram_re       = 1'b0;
    ram_raddr    = word_q;
    unique case (state_q)
      ST_SWEEP: begin
        ram_we = 1'b1;
        word_d = sweep_last ? '0 : word_q + AW'(1);
      end
      ST_IDLE: begin
        if (acc) begin
          is_free_d = in_beat_i.func == FUNC_FREE;
          size_d    = in_beat_i.size_bytes;
          res_ok_d  = 1'b0;
          res_hit_d = 1'b0;
          word_d    = '0;
          case (in_beat_i.func)
            FUNC_ALLOC: div_start = 1'b1;
            FUNC_FREE: begin
              div_start    = 1'b1;
              div_dividend = in_beat_i.offset_in;
            end
            FUNC_CLEAR: begin
              res_ok_d = 1'b1;
              pend_d   = 1'b1;
            end
            default: ;
          endcase
        end
      end
      ST_DIV1: begin
        if (div_res.done) begin
          if (is_free_q) begin
            first_d      = div_res.quot;
            div_start    = 1'b1;
            div_dividend = size_q;
          end else begin
            need_d  = IX_W'(blocks_ext);
            run_d   = '0;
            start_d = '0;
            word_d  = '0;
          end
        end
      end
      ST_DIV2: begin
        if (div_res.done) begin
          res_ok_d = 1'b1;
          lo_d     = IX_W'(first_q);
          hi_d     = IX_W'(hi_ext);
          set_d    = 1'b0;
          word_d   = AW'(first_q >> WORD_SH);
        end
      end
      ST_SCAN_RD: begin
        ram_re = 1'b1;
      end
      ST_SCAN_EV: begin
        run_d   = run_c;
        start_d = start_c;
        if (found_c) begin
          res_ok_d  = 1'b1;
          res_hit_d = 1'b1;
          lo_d      = start_c;
          hi_d      = start_c + need_q;
          set_d     = 1'b1;
          word_d    = AW'(start_c >> WORD_SH);
        end else if (!scan_last) begin
          word_d = word_q + AW'(1);
        end
      end
      ST_MARK_RD: begin
        ram_re = 1'b1;
      end
      ST_MARK_WR: begin
        ram_we    = 1'b1;
        ram_wdata = mark_data;
        if (!mark_last) begin
          word_d = word_q + AW'(1);
        end
      end
      ST_DONE: begin
        if (out_free) begin
          pend_d                = 1'b0;
          out_valid_d           = 1'b1;
          out_beat_d.ok         = res_ok_q;
          out_beat_d.head_block = res_hit_q ? HEAD_W'(start_q) : '0;
          out_beat_d.offset_out = res_hit_q ? SIZE_W'(prod) : '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_SWEEP;
      word_q      <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      word_q      <= word_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    run_q      <= run_d;
    start_q    <= start_d;
    need_q     <= need_d;
    lo_q       <= lo_d;
    hi_q       <= hi_d;
    set_q      <= set_d;
    is_free_q  <= is_free_d;
    size_q     <= size_d;
    first_q    <= first_d;
    res_ok_q   <= res_ok_d;
    res_hit_q  <= res_hit_d;
    out_beat_q <= out_beat_d;
  end

  assign in_stall_o  = state_q != ST_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_beat_q;

  a_take_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |=> in_stall_o)
    else $error("second beat taken while busy");

  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE || state_q == ST_DONE) |-> !ram_we)
    else $error("bitmap written outside an operation");

  a_div_done_owned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_res.done |-> (state_q == ST_DIV1 || state_q == ST_DIV2))
    else $error("divider finished with no waiting step");

  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && state_q != ST_DONE) |=> !out_valid_o)
    else $error("result beat repeated");

endmodule
